FILE: rtl/tbbe_pkg.sv
package tbbe_pkg;

    localparam int COORD_W       = 16;
    localparam int RES_W         = 32;
    localparam int ROW_W         = 64;
    localparam int PROD_W        = 2 * COORD_W;
    localparam int TRANS_W       = COORD_W + 8;
    localparam int SUM_W         = RES_W + 2;
    localparam int EDGE_W        = 4;
    localparam int NUM_ENDPOINTS = 24;
    localparam int CNT_W         = 5;
    localparam int ADDR_W        = 5;

    typedef logic signed [RES_W-1:0]   coord_t;
    typedef logic signed [COORD_W-1:0] pos_t;
    typedef logic [ROW_W-1:0]          row_t;
    typedef logic [2:0]                corner_t;
    typedef logic [CNT_W-1:0]          ep_cnt_t;

    typedef enum logic [1:0] {
        REG_ROW_X = 2'd0,
        REG_ROW_Y = 2'd1,
        REG_ROW_Z = 2'd2
    } reg_idx_t;

    localparam row_t    ROW_X_RESET = 64'd256;
    localparam row_t    ROW_Y_RESET = 64'd1 << 24;
    localparam row_t    ROW_Z_RESET = 64'd1 << 40;
    localparam coord_t  COORD_MAX   = 32'sh7FFF_FFFF;
    localparam coord_t  COORD_MIN   = 32'sh8000_0000;
    localparam ep_cnt_t LAST_EP     = ep_cnt_t'(NUM_ENDPOINTS - 1);

    // bottom 0-1 1-2 2-3 3-0, top 4-5 5-6 6-7 7-4, sides 0-4 1-5 2-6 3-7
    function automatic corner_t edge_corner(input ep_cnt_t k);
        corner_t c;
        case (k)
            5'd0:    c = 3'd0;
            5'd1:    c = 3'd1;
            5'd2:    c = 3'd1;
            5'd3:    c = 3'd2;
            5'd4:    c = 3'd2;
            5'd5:    c = 3'd3;
            5'd6:    c = 3'd3;
            5'd7:    c = 3'd0;
            5'd8:    c = 3'd4;
            5'd9:    c = 3'd5;
            5'd10:   c = 3'd5;
            5'd11:   c = 3'd6;
            5'd12:   c = 3'd6;
            5'd13:   c = 3'd7;
            5'd14:   c = 3'd7;
            5'd15:   c = 3'd4;
            5'd16:   c = 3'd0;
            5'd17:   c = 3'd4;
            5'd18:   c = 3'd1;
            5'd19:   c = 3'd5;
            5'd20:   c = 3'd2;
            5'd21:   c = 3'd6;
            5'd22:   c = 3'd3;
            5'd23:   c = 3'd7;
            default: c = 3'd0;
        endcase
        return c;
    endfunction

    function automatic logic corner_hi_x(input corner_t c);
        return (c == 3'd1) || (c == 3'd2) || (c == 3'd5) || (c == 3'd6);
    endfunction

    function automatic logic corner_hi_y(input corner_t c);
        return c[2];
    endfunction

    function automatic logic corner_hi_z(input corner_t c);
        return (c == 3'd2) || (c == 3'd3) || (c == 3'd6) || (c == 3'd7);
    endfunction

endpackage

FILE: rtl/tbbe_axis.sv
module tbbe_axis (
    input  logic            clk,
    input  logic            en,
    input  tbbe_pkg::row_t  row,
    input  tbbe_pkg::pos_t  px,
    input  tbbe_pkg::pos_t  py,
    input  tbbe_pkg::pos_t  pz,
    output tbbe_pkg::coord_t coord
);
    import tbbe_pkg::*;

    logic signed [PROD_W-1:0]  prod_x_reg, prod_x_next;
    logic signed [PROD_W-1:0]  prod_y_reg, prod_y_next;
    logic signed [PROD_W-1:0]  prod_z_reg, prod_z_next;
    logic signed [TRANS_W-1:0] trans_reg, trans_next;
    logic signed [SUM_W-1:0]   sum;
    coord_t                    coord_reg, coord_next;

    always_comb
    begin
        prod_x_next = $signed(row[15:0])  * px;
        prod_y_next = $signed(row[31:16]) * py;
        prod_z_next = $signed(row[47:32]) * pz;
        trans_next  = $signed({row[63:48], 8'h00});
    end

    always_comb
    begin
        sum = $signed({{(SUM_W-PROD_W){prod_x_reg[PROD_W-1]}}, prod_x_reg})
            + $signed({{(SUM_W-PROD_W){prod_y_reg[PROD_W-1]}}, prod_y_reg})
            + $signed({{(SUM_W-PROD_W){prod_z_reg[PROD_W-1]}}, prod_z_reg})
            + $signed({{(SUM_W-TRANS_W){trans_reg[TRANS_W-1]}}, trans_reg});
        if (sum[SUM_W-1:RES_W-1] == '0 || sum[SUM_W-1:RES_W-1] == '1)
            coord_next = sum[RES_W-1:0];
        else if (sum[SUM_W-1])
            coord_next = COORD_MIN;
        else
            coord_next = COORD_MAX;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_x_reg <= prod_x_next;
            prod_y_reg <= prod_y_next;
            prod_z_reg <= prod_z_next;
            trans_reg  <= trans_next;
            coord_reg  <= coord_next;
        end
    end

    assign coord = coord_reg;

endmodule

FILE: rtl/transformed_bounding_box_edges_core.sv
// channel | dir | handshake             | payload
// --------+-----+-----------------------+-------------------------------------------
// in      | in  | in_valid / in_stall   | pos_x, pos_y, pos_z, last_vertex
// out     | out | out_valid / out_stall | end_x, end_y, end_z, edge_number,
//         |     |                       | endpoint_select, last_of_run
// apb     | in  | psel/penable/pready   | paddr, pwdata, prdata (row_x @0, y @8, z @16)
//
// One vertex per cycle while in_stall is low: input, product and sum-and-saturate registers,
// then the min/max update into the extremes registers.
// A last vertex loads the box buffer, which sends 24 endpoint words, one per unstalled cycle.
// in_stall rises only while a last vertex waits at the min/max stage for the previous
// box to finish; the whole pipeline then holds.
// rst_n drops the valid bits and resets the extremes and rows; box data is not reset.
module transformed_bounding_box_edges_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  tbbe_pkg::pos_t                pos_x,
    input  tbbe_pkg::pos_t                pos_y,
    input  tbbe_pkg::pos_t                pos_z,
    input  logic                          last_vertex,
    output logic                          out_valid,
    input  logic                          out_stall,
    output tbbe_pkg::coord_t              end_x,
    output tbbe_pkg::coord_t              end_y,
    output tbbe_pkg::coord_t              end_z,
    output logic [tbbe_pkg::EDGE_W-1:0]   edge_number,
    output logic                          endpoint_select,
    output logic                          last_of_run,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tbbe_pkg::ADDR_W-1:0]   paddr,
    input  tbbe_pkg::row_t                pwdata,
    output tbbe_pkg::row_t                prdata,
    output logic                          pready
);
    import tbbe_pkg::*;

    row_t     row_x_reg, row_y_reg, row_z_reg;
    reg_idx_t cfg_idx;
    logic     cfg_write;

    logic     go;
    logic     box_free;
    logic     out_accept;

    pos_t     s1_x_reg, s1_y_reg, s1_z_reg;
    logic     s1_valid_reg, s1_last_reg;
    logic     s2_valid_reg, s2_last_reg;
    logic     s3_valid_reg, s3_last_reg;
    coord_t   tx, ty, tz;

    coord_t   lo_x_reg, lo_y_reg, lo_z_reg, hi_x_reg, hi_y_reg, hi_z_reg;
    coord_t   lo_x_next, lo_y_next, lo_z_next, hi_x_next, hi_y_next, hi_z_next;

    coord_t   box_lo_x_reg, box_lo_y_reg, box_lo_z_reg;
    coord_t   box_hi_x_reg, box_hi_y_reg, box_hi_z_reg;
    logic     box_valid_reg;
    ep_cnt_t  cnt_reg;
    corner_t  corner;
    logic     box_load;

    // configuration
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = reg_idx_t'(paddr[ADDR_W-1:3]);

    always_comb
    begin
        case (cfg_idx)
            REG_ROW_X: prdata = row_x_reg;
            REG_ROW_Y: prdata = row_y_reg;
            REG_ROW_Z: prdata = row_z_reg;
            default:   prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_x_reg <= ROW_X_RESET;
            row_y_reg <= ROW_Y_RESET;
            row_z_reg <= ROW_Z_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                REG_ROW_X: row_x_reg <= pwdata;
                REG_ROW_Y: row_y_reg <= pwdata;
                REG_ROW_Z: row_z_reg <= pwdata;
                default:   ;
            endcase
        end
    end

    // pipeline control
    assign out_accept = box_valid_reg && !out_stall;
    assign box_free   = !box_valid_reg || (out_accept && cnt_reg == LAST_EP);
    assign go         = !(s3_valid_reg && s3_last_reg && !box_free);
    assign in_stall   = !go;
    assign box_load   = go && s3_valid_reg && s3_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (go)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            s1_x_reg    <= pos_x;
            s1_y_reg    <= pos_y;
            s1_z_reg    <= pos_z;
            s1_last_reg <= last_vertex;
            s2_last_reg <= s1_last_reg;
            s3_last_reg <= s2_last_reg;
        end
    end

    tbbe_axis u_axis_x (
        .clk   (clk),
        .en    (go),
        .row   (row_x_reg),
        .px    (s1_x_reg),
        .py    (s1_y_reg),
        .pz    (s1_z_reg),
        .coord (tx)
    );

    tbbe_axis u_axis_y (
        .clk   (clk),
        .en    (go),
        .row   (row_y_reg),
        .px    (s1_x_reg),
        .py    (s1_y_reg),
        .pz    (s1_z_reg),
        .coord (ty)
    );

    tbbe_axis u_axis_z (
        .clk   (clk),
        .en    (go),
        .row   (row_z_reg),
        .px    (s1_x_reg),
        .py    (s1_y_reg),
        .pz    (s1_z_reg),
        .coord (tz)
    );

    // extremes
    always_comb
    begin
        lo_x_next = (tx < lo_x_reg) ? tx : lo_x_reg;
        lo_y_next = (ty < lo_y_reg) ? ty : lo_y_reg;
        lo_z_next = (tz < lo_z_reg) ? tz : lo_z_reg;
        hi_x_next = (tx > hi_x_reg) ? tx : hi_x_reg;
        hi_y_next = (ty > hi_y_reg) ? ty : hi_y_reg;
        hi_z_next = (tz > hi_z_reg) ? tz : hi_z_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_x_reg <= COORD_MAX;
            lo_y_reg <= COORD_MAX;
            lo_z_reg <= COORD_MAX;
            hi_x_reg <= COORD_MIN;
            hi_y_reg <= COORD_MIN;
            hi_z_reg <= COORD_MIN;
        end
        else if (box_load)
        begin
            lo_x_reg <= COORD_MAX;
            lo_y_reg <= COORD_MAX;
            lo_z_reg <= COORD_MAX;
            hi_x_reg <= COORD_MIN;
            hi_y_reg <= COORD_MIN;
            hi_z_reg <= COORD_MIN;
        end
        else if (go && s3_valid_reg)
        begin
            lo_x_reg <= lo_x_next;
            lo_y_reg <= lo_y_next;
            lo_z_reg <= lo_z_next;
            hi_x_reg <= hi_x_next;
            hi_y_reg <= hi_y_next;
            hi_z_reg <= hi_z_next;
        end
    end

    // box buffer
    always_ff @(posedge clk)
    begin
        if (box_load)
        begin
            box_lo_x_reg <= lo_x_next;
            box_lo_y_reg <= lo_y_next;
            box_lo_z_reg <= lo_z_next;
            box_hi_x_reg <= hi_x_next;
            box_hi_y_reg <= hi_y_next;
            box_hi_z_reg <= hi_z_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else if (box_load)
        begin
            box_valid_reg <= 1'b1;
            cnt_reg       <= '0;
        end
        else if (out_accept)
        begin
            if (cnt_reg == LAST_EP)
            begin
                box_valid_reg <= 1'b0;
                cnt_reg       <= '0;
            end
            else
            begin
                cnt_reg <= cnt_reg + ep_cnt_t'(1);
            end
        end
    end

    assign corner          = edge_corner(cnt_reg);
    assign out_valid       = box_valid_reg;
    assign end_x           = corner_hi_x(corner) ? box_hi_x_reg : box_lo_x_reg;
    assign end_y           = corner_hi_y(corner) ? box_hi_y_reg : box_lo_y_reg;
    assign end_z           = corner_hi_z(corner) ? box_hi_z_reg : box_lo_z_reg;
    assign edge_number     = cnt_reg[CNT_W-1:1];
    assign endpoint_select = cnt_reg[0];
    assign last_of_run     = (cnt_reg == LAST_EP);

    a_cnt_range : assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= LAST_EP)
        else $error("endpoint counter out of range");

    a_box_start : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> cnt_reg == '0)
        else $error("box started mid-run");

    a_hold_on_busy : assert property (@(posedge clk) disable iff (!rst_n)
        (s3_valid_reg && s3_last_reg && box_valid_reg && out_stall) |-> in_stall)
        else $error("last vertex advanced over a busy box buffer");

    a_extremes_cleared : assert property (@(posedge clk) disable iff (!rst_n)
        box_load |=> (lo_x_reg == COORD_MAX && hi_z_reg == COORD_MIN))
        else $error("extremes not cleared after box");

endmodule

FILE: tb/box_edge_checker.sv
module box_edge_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  tbbe_pkg::pos_t                pos_x,
    input  tbbe_pkg::pos_t                pos_y,
    input  tbbe_pkg::pos_t                pos_z,
    input  logic                          last_vertex,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  tbbe_pkg::coord_t              end_x,
    input  tbbe_pkg::coord_t              end_y,
    input  tbbe_pkg::coord_t              end_z,
    input  logic [tbbe_pkg::EDGE_W-1:0]   edge_number,
    input  logic                          endpoint_select,
    input  logic                          last_of_run,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tbbe_pkg::ADDR_W-1:0]   paddr,
    input  tbbe_pkg::row_t                pwdata,
    input  logic                          pready,
    output int                            mismatches,
    output int                            outstanding,
    output int                            vertices_seen,
    output int                            boxes_seen
);
    import tbbe_pkg::*;

    typedef struct packed {
        coord_t            x;
        coord_t            y;
        coord_t            z;
        logic [EDGE_W-1:0] edge_no;
        logic              sel;
        logic              last;
    } endpoint_t;

    row_t      row_x_q;
    row_t      row_y_q;
    row_t      row_z_q;
    coord_t    lo_x, lo_y, lo_z;
    coord_t    hi_x, hi_y, hi_z;
    endpoint_t endpoint_q[$];

    function automatic coord_t apply_row(input row_t row, input pos_t px, input pos_t py,
                                         input pos_t pz);
        longint sum;
        sum = longint'($signed(row[15:0])) * longint'(px)
            + longint'($signed(row[31:16])) * longint'(py)
            + longint'($signed(row[47:32])) * longint'(pz)
            + longint'($signed(row[63:48])) * 256;
        if (sum > longint'(COORD_MAX))
            return COORD_MAX;
        if (sum < longint'(COORD_MIN))
            return COORD_MIN;
        return coord_t'(sum);
    endfunction

    task automatic clear_box();
        lo_x = COORD_MAX;
        lo_y = COORD_MAX;
        lo_z = COORD_MAX;
        hi_x = COORD_MIN;
        hi_y = COORD_MIN;
        hi_z = COORD_MIN;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        endpoint_t want;
        endpoint_t got;
        coord_t    tx, ty, tz;
        int        face_j;
        logic      hx, hy, hz;
        if (!rst_n)
        begin
            row_x_q = ROW_X_RESET;
            row_y_q = ROW_Y_RESET;
            row_z_q = ROW_Z_RESET;
            clear_box();
            endpoint_q.delete();
            mismatches = 0;
            vertices_seen = 0;
            boxes_seen = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[ADDR_W-1:3])
                    REG_ROW_X: row_x_q = pwdata;
                    REG_ROW_Y: row_y_q = pwdata;
                    REG_ROW_Z: row_z_q = pwdata;
                    default: ;
                endcase
            end

            if (out_valid && !out_stall)
            begin
                got = '{end_x, end_y, end_z, edge_number, endpoint_select, last_of_run};
                if (endpoint_q.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("unexpected word: x %h y %h z %h edge %0d sel %b last %b",
                                 got.x, got.y, got.z, got.edge_no, got.sel, got.last);
                    mismatches++;
                end
                else
                begin
                    want = endpoint_q.pop_front();
                    if (got !== want)
                    begin
                        if (mismatches < 10)
                        begin
                            $display("mismatch, expected x %h y %h z %h edge %0d sel %b last %b",
                                     want.x, want.y, want.z, want.edge_no, want.sel, want.last);
                            $display("               got x %h y %h z %h edge %0d sel %b last %b",
                                     got.x, got.y, got.z, got.edge_no, got.sel, got.last);
                        end
                        mismatches++;
                    end
                end
            end

            if (in_valid && !in_stall)
            begin
                vertices_seen++;
                tx = apply_row(row_x_q, pos_x, pos_y, pos_z);
                ty = apply_row(row_y_q, pos_x, pos_y, pos_z);
                tz = apply_row(row_z_q, pos_x, pos_y, pos_z);
                if (tx < lo_x) lo_x = tx;
                if (ty < lo_y) lo_y = ty;
                if (tz < lo_z) lo_z = tz;
                if (tx > hi_x) hi_x = tx;
                if (ty > hi_y) hi_y = ty;
                if (tz > hi_z) hi_z = tz;
                if (last_vertex)
                begin
                    boxes_seen++;
                    // bottom, top as rings: (lo,lo) (hi,lo) (hi,hi) (lo,hi) in x,z, then sides
                    for (int k = 0; k < NUM_ENDPOINTS; k++)
                    begin
                        if (k < 16)
                        begin
                            face_j = ((k >> 1) + (k & 1)) % 4;
                            hy = (k >= 8);
                        end
                        else
                        begin
                            face_j = (k >> 1) - 8;
                            hy = k[0];
                        end
                        hx = (face_j == 1) || (face_j == 2);
                        hz = (face_j >= 2);
                        want.x = hx ? hi_x : lo_x;
                        want.y = hy ? hi_y : lo_y;
                        want.z = hz ? hi_z : lo_z;
                        want.edge_no = EDGE_W'(k >> 1);
                        want.sel = k[0];
                        want.last = (k == NUM_ENDPOINTS - 1);
                        endpoint_q.push_back(want);
                    end
                    clear_box();
                end
            end
        end
        outstanding = endpoint_q.size();
    end

endmodule

FILE: tb/testbench.sv
module testbench;
    import tbbe_pkg::*;

    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          DRAIN_CYCLES   = 16;
    localparam logic [1:0]  REG_NONE       = 2'd3;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    pos_t                pos_x;
    pos_t                pos_y;
    pos_t                pos_z;
    logic                last_vertex;
    logic                out_valid;
    logic                out_stall = 1'b0;
    coord_t              end_x;
    coord_t              end_y;
    coord_t              end_z;
    logic [EDGE_W-1:0]   edge_number;
    logic                endpoint_select;
    logic                last_of_run;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    row_t                pwdata;
    row_t                prdata;
    logic                pready;
    int                  mismatches;
    int                  outstanding;
    int                  vertices_seen;
    int                  boxes_seen;

    int                  send_idle_pct = 35;
    int                  recv_idle_pct = 46;
    int                  row_settings = 1;
    int                  quiet_cycles = 0;

    transformed_bounding_box_edges_core dut (.*);
    box_edge_checker edge_check (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(negedge clk)
        out_stall <= ($urandom_range(99) < recv_idle_pct);

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL transformed_bounding_box_edges_core");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic send_vertex(input pos_t x, input pos_t y, input pos_t z, input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        pos_x       <= x;
        pos_y       <= y;
        pos_z       <= z;
        last_vertex <= last;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    // drop valid, wait out every box, then let the pipeline empty
    task automatic settle();
        in_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic apb_write(input logic [ADDR_W-1:0] addr, input row_t data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic [15:0] pick_q88();
        case ($urandom_range(0, 5))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            5:       return 16'($urandom);
            default: return 16'($signed($urandom_range(0, 1023)) - 512);
        endcase
    endfunction

    function automatic pos_t pick_pos();
        if ($urandom_range(0, 2) == 0)
            return pos_t'($urandom);
        return pos_t'($signed($urandom_range(0, 4095)) - 2048);
    endfunction

    task automatic load_random_rows();
        apb_write({REG_ROW_X, 3'b000}, {pick_q88(), pick_q88(), pick_q88(), pick_q88()});
        apb_write({REG_ROW_Y, 3'b000}, {pick_q88(), pick_q88(), pick_q88(), pick_q88()});
        apb_write({REG_ROW_Z, 3'b000}, {pick_q88(), pick_q88(), pick_q88(), pick_q88()});
        row_settings++;
    endtask

    initial
    begin
        int sent;
        int run_len;
        in_valid    = 1'b0;
        pos_x       = '0;
        pos_y       = '0;
        pos_z       = '0;
        last_vertex = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        rst_n       = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset rows: identity; single-vertex boxes back to back and one three-vertex box
        send_vertex(16'sh0000, 16'sh0000, 16'sh0000, 1'b1);
        send_vertex(16'sh7FFF, 16'sh8000, 16'sh0001, 1'b1);
        send_vertex(16'sh8000, 16'sh7FFF, 16'shFFFF, 1'b1);
        send_vertex(16'sh8000, 16'sh8000, 16'sh8000, 1'b0);
        send_vertex(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b0);
        send_vertex(16'sh5555, 16'shAAAA, 16'sh5555, 1'b1);
        send_vertex(16'shAAAA, 16'sh5555, 16'shAAAA, 1'b1);

        // saturating rows, plus a write to an unmapped slot that must be ignored
        settle();
        apb_write({REG_ROW_X, 3'b000}, 64'h7FFF_7FFF_7FFF_7FFF);
        apb_write({REG_ROW_Y, 3'b000}, 64'h8000_8000_8000_8000);
        apb_write({REG_ROW_Z, 3'b000}, 64'h0000_0000_0000_0000);
        apb_write({REG_NONE, 3'b000}, 64'hFFFF_FFFF_FFFF_FFFF);
        row_settings++;
        send_vertex(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b1);
        send_vertex(16'sh8000, 16'sh8000, 16'sh8000, 1'b1);
        send_vertex(16'sh0000, 16'sh0000, 16'sh0000, 1'b0);
        send_vertex(16'sh7FFF, 16'sh8000, 16'sh7FFF, 1'b0);
        send_vertex(16'sh0100, 16'shFF00, 16'sh0080, 1'b1);

        settle();
        apb_write({REG_ROW_X, 3'b000}, 64'hFFFF_FFFF_FFFF_FFFF);
        apb_write({REG_ROW_Y, 3'b000}, 64'h7FFF_0000_0100_8000);
        apb_write({REG_ROW_Z, 3'b000}, 64'h8000_0100_0000_0000);
        row_settings++;
        send_vertex(16'sh8000, 16'sh7FFF, 16'sh0000, 1'b0);
        send_vertex(16'sh7FFF, 16'sh8000, 16'shFFFF, 1'b0);
        send_vertex(16'sh0001, 16'sh0000, 16'sh8000, 1'b1);
        send_vertex(16'sh1234, 16'shEDCB, 16'sh7FFF, 1'b1);

        for (int phase = 0; phase < 3; phase++)
        begin
            settle();
            case (phase)
                0:
                begin
                    send_idle_pct = 35;
                    recv_idle_pct = 46;
                end
                1:
                begin
                    send_idle_pct = 46;
                    recv_idle_pct = 35;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int seg = 0; seg < 2; seg++)
            begin
                settle();
                load_random_rows();
                sent = 0;
                while (sent < 50)
                begin
                    run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                          : $urandom_range(1, 6);
                    for (int i = 0; i < run_len; i++)
                        send_vertex(pick_pos(), pick_pos(), pick_pos(), i == run_len - 1);
                    sent += run_len;
                end
            end
        end

        settle();
        $display("covered %0d vertices in %0d boxes (%0d endpoint words) over %0d row settings,",
                 vertices_seen, boxes_seen, boxes_seen * NUM_ENDPOINTS, row_settings);
        $display("including saturating rows, single-vertex boxes and an unmapped register write");
        if (mismatches == 0 && outstanding == 0)
            $display("PASS transformed_bounding_box_edges_core");
        else
            $display("FAIL transformed_bounding_box_edges_core");
        $finish;
    end

endmodule
